// ===== sv/polyphonic_dds_synth_with_envelope_unit_assert.svh =====
// Assertion macros for the polyphonic DDS synth.
`ifndef POLYPHONIC_DDS_SYNTH_WITH_ENVELOPE_UNIT_ASSERT_SVH
`define POLYPHONIC_DDS_SYNTH_WITH_ENVELOPE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PDDS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pdds assertion failed");
`define PDDS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pdds forbidden condition");
`else
`define PDDS_ASSERT(lbl, clk, rst, prop)
`define PDDS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== sv/pdds_pkg.sv =====
// Shared types, constants and table functions of the DDS synth.
`timescale 1ns / 1ps
package pdds_pkg;

   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_PRESS   = 2'd1;
   localparam logic [1:0] FUNC_RELEASE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR   = 2'd3;

   localparam logic [2:0] REG_ATTACK  = 3'd0;
   localparam logic [2:0] REG_DECAY   = 3'd1;
   localparam logic [2:0] REG_SUSTAIN = 3'd2;
   localparam logic [2:0] REG_VOLUME  = 3'd3;
   localparam logic [2:0] REG_WAVE    = 3'd4;
   localparam logic [2:0] REG_TPM     = 3'd5;

   localparam logic [1:0] WAVE_SAW    = 2'd0;
   localparam logic [1:0] WAVE_SINE   = 2'd1;
   localparam logic [1:0] WAVE_TRI    = 2'd2;
   localparam logic [1:0] WAVE_SQUARE = 2'd3;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 9;
   localparam int DIV_NUM_W = 28;
   localparam int DIV_DEN_W = 13;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] note;
      logic [3:0] octave;
   } req_type;

   typedef struct packed {
      logic [7:0] audio_sample;
      logic [3:0] voice_count;
   } rsp_type;

   localparam logic [31:0] NOTE_STEP [12] = '{
      32'd51076056, 32'd54113197, 32'd57330935, 32'd60740009,
      32'd64351798, 32'd68178356, 32'd72232452, 32'd76527617,
      32'd81078186, 32'd85899345, 32'd91007186, 32'd96418755};

   localparam logic [6:0] QSINE [65] = '{
      7'd0, 7'd3, 7'd6, 7'd9, 7'd12, 7'd15, 7'd18, 7'd21,
      7'd24, 7'd27, 7'd30, 7'd33, 7'd36, 7'd39, 7'd42, 7'd45,
      7'd48, 7'd51, 7'd54, 7'd57, 7'd59, 7'd62, 7'd65, 7'd67,
      7'd70, 7'd73, 7'd75, 7'd78, 7'd80, 7'd82, 7'd85, 7'd87,
      7'd89, 7'd91, 7'd94, 7'd96, 7'd98, 7'd100, 7'd102, 7'd103,
      7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
      7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
      7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
      7'd127};

   // phase step of a note, zero for notes above B
   function automatic logic [31:0] step_for(logic [3:0] note, logic [3:0] octave);
      logic [31:0] s;
      s = '0;
      if (note < 4'd12) begin
         s = NOTE_STEP[note];
         if (octave >= 4'd4) s = s << (octave - 4'd4);
         else s = s >> (4'd4 - octave);
      end
      return s;
   endfunction

   function automatic logic signed [7:0] wave_value(logic [7:0] idx, logic [1:0] sel);
      logic [6:0] j;
      logic [6:0] v;
      logic [6:0] t;
      logic signed [7:0] r;
      j = idx[6:0];
      v = (j <= 7'd64) ? QSINE[j] : QSINE[7'(8'd128 - {1'b0, j})];
      t = idx[7] ? ~idx[6:0] : idx[6:0];
      unique case (sel)
         WAVE_SAW:  r = {~idx[7], idx[6:0]};
         WAVE_SINE: r = idx[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
         WAVE_TRI:  r = {~t[6], t[5:0], 1'b0};
         default:   r = idx[7] ? 8'sd127 : -8'sd128;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/polyphonic_dds_synth_with_envelope_unit.sv =====
// Polyphonic DDS synth top level: event sequencer, envelope and output stage.
`timescale 1ns / 1ps
// Takes one event item at a time. Press, clear and tick-free events: a press
// or clear completes in the accept cycle; a release walks the voice step
// memory. A sample tick walks every slot through the step/phase memories
// (one slot per cycle), then runs the envelope divide and the mean divide on
// one shared 28-bit serial divider (the mean divide skipped with no active
// voice) and scales. Each tick returns one result item held in an output
// register, so the next event is taken while a result waits. Slot busy bits
// and phase valid bits are flip-flops cleared by reset, so no clearing pass
// is needed.
module polyphonic_dds_synth_with_envelope_unit #(
   parameter int VOICES = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pdds_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pdds_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [pdds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdds_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pdds_pkg::*;
`include "polyphonic_dds_synth_with_envelope_unit_assert.svh"

   localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CNT_W = $clog2(VOICES + 1);
   localparam int SUM_W = $clog2(VOICES) + 9;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_WALK      = 8'b0000_0010,
      ST_ENV       = 8'b0000_0100,
      ST_ENV_WAIT  = 8'b0000_1000,
      ST_MEAN      = 8'b0001_0000,
      ST_MEAN_WAIT = 8'b0010_0000,
      ST_SCALE     = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   // configuration
   logic [8:0] attack_ff, decay_ff;
   logic [3:0] sustain_ff, volume_ff;
   logic [1:0] wave_ff;
   logic [7:0] tpm_ff;

   state_type state_ff;
   logic [VOICES-1:0] busy_ff, phase_ok_ff;
   logic              is_release_ff;
   logic [31:0]       target_ff;
   logic              found_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic              proc_vld_ff;
   logic [SLOT_W-1:0] proc_idx_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [15:0]       elapsed_ff;
   logic [7:0]        tick_ff;
   logic              decay_sel_ff;
   logic [15:0]       level_ff;
   logic signed [8:0] mean_ff;
   logic signed [25:0] prod_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic accept;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   // press: step and first free slot
   logic [31:0]       req_step;
   logic              free_hit;
   logic [SLOT_W-1:0] free_slot;
   assign req_step = step_for(req_data.note, req_data.octave);
   always_comb begin
      free_hit = 1'b0;
      free_slot = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_hit = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   // voice memories
   logic [31:0] rd_step, rd_phase, new_phase;
   logic        step_we, phase_we;
   assign step_we = accept && (req_data.func == FUNC_PRESS) && (req_step != '0) && free_hit;
   assign new_phase = (phase_ok_ff[proc_idx_ff] ? rd_phase : 32'd0) + rd_step;
   assign phase_we = proc_vld_ff && !is_release_ff && busy_ff[proc_idx_ff];

   pdds_voice_mem #(.VOICES(VOICES), .SLOT_W(SLOT_W)) u_mem (
      .clock(clock),
      .rd_addr(rd_idx_ff[SLOT_W-1:0]),
      .rd_step(rd_step),
      .rd_phase(rd_phase),
      .step_we(step_we),
      .step_waddr(free_slot),
      .step_wdata(req_step),
      .phase_we(phase_we),
      .phase_waddr(proc_idx_ff),
      .phase_wdata(new_phase)
   );

   // envelope operands
   logic [3:0]  sus_cl;
   logic [15:0] e_minus_a;
   logic        in_attack, in_decay;
   logic [DIV_NUM_W-1:0] env_num, div_num;
   logic [DIV_DEN_W-1:0] env_den, div_den;
   logic [12:0] decay_prod;
   assign sus_cl = (sustain_ff > 4'd10) ? 4'd10 : sustain_ff;
   assign e_minus_a = elapsed_ff - {7'd0, attack_ff};
   assign in_attack = elapsed_ff < {7'd0, attack_ff};
   assign in_decay = !in_attack && (e_minus_a < {7'd0, decay_ff});
   assign decay_prod = (4'd10 - sus_cl) * e_minus_a[8:0];
   always_comb begin
      priority if (in_attack) begin
         env_num = DIV_NUM_W'({elapsed_ff[8:0], 15'd0});
         env_den = DIV_DEN_W'(attack_ff);
      end else if (in_decay) begin
         env_num = DIV_NUM_W'({decay_prod, 15'd0});
         env_den = DIV_DEN_W'(decay_ff) * DIV_DEN_W'(4'd10);
      end else begin
         env_num = DIV_NUM_W'({sus_cl, 15'd0});
         env_den = DIV_DEN_W'(10);
      end
   end

   // shared divider: envelope level, then the mean
   logic sum_neg;
   logic [SUM_W-1:0] sum_mag;
   logic div_start, div_busy, div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   assign sum_neg = sum_ff[SUM_W-1];
   assign sum_mag = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_start = (state_ff == ST_ENV) || ((state_ff == ST_MEAN) && (count_ff != '0));
   assign div_num = (state_ff == ST_ENV) ? env_num : DIV_NUM_W'(sum_mag);
   assign div_den = (state_ff == ST_ENV) ? env_den : DIV_DEN_W'(count_ff);

   pdds_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .busy(div_busy),
      .done(div_done),
      .quo(div_quo)
   );

   // output stage: truncate toward zero, volume shift, offset
   logic [25:0] prod_mag;
   logic [7:0]  scaled_mag;
   logic [9:0]  scaled, biased;
   logic [3:0]  vol_sh;
   logic [7:0]  sample;
   assign prod_mag = prod_ff[25] ? 26'(-prod_ff) : 26'(prod_ff);
   assign scaled_mag = prod_mag[22:15];
   assign scaled = prod_ff[25] ? 10'(-{2'b00, scaled_mag}) : {2'b00, scaled_mag};
   assign biased = scaled + 10'd256;
   assign vol_sh = (volume_ff > 4'd8) ? 4'd0 : 4'd8 - volume_ff;
   assign sample = 8'((biased >> vol_sh) - (10'd256 >> vol_sh) + 10'd128);

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   logic [8:0] tick_next;
   assign tick_next = {1'b0, tick_ff} + 9'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff <= 9'd50;
         decay_ff <= 9'd100;
         sustain_ff <= 4'd7;
         volume_ff <= 4'd8;
         wave_ff <= WAVE_SINE;
         tpm_ff <= 8'd22;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ATTACK:  attack_ff <= csr_wdata;
            REG_DECAY:   decay_ff <= csr_wdata;
            REG_SUSTAIN: sustain_ff <= csr_wdata[3:0];
            REG_VOLUME:  volume_ff <= csr_wdata[3:0];
            REG_WAVE:    wave_ff <= csr_wdata[1:0];
            REG_TPM:     tpm_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff <= '0;
         phase_ok_ff <= '0;
         proc_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         elapsed_ff <= '0;
         tick_ff <= '0;
      end else begin
         // ST_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_data.func)
                     FUNC_PRESS: begin
                        if (step_we) busy_ff[free_slot] <= 1'b1;
                        elapsed_ff <= '0;
                        tick_ff <= '0;
                     end
                     FUNC_CLEAR: busy_ff <= '0;
                     FUNC_RELEASE: begin
                        is_release_ff <= 1'b1;
                        target_ff <= req_step;
                        found_ff <= (req_step == '0);
                        rd_idx_ff <= '0;
                        state_ff <= ST_WALK;
                     end
                     default: begin
                        is_release_ff <= 1'b0;
                        sum_ff <= '0;
                        count_ff <= '0;
                        rd_idx_ff <= '0;
                        state_ff <= ST_WALK;
                     end
                  endcase
               end
            end
            ST_WALK: begin
               proc_vld_ff <= (rd_idx_ff != CNT_W'(VOICES));
               proc_idx_ff <= rd_idx_ff[SLOT_W-1:0];
               if (rd_idx_ff != CNT_W'(VOICES)) rd_idx_ff <= rd_idx_ff + 1'b1;
               if (proc_vld_ff && busy_ff[proc_idx_ff]) begin
                  if (is_release_ff) begin
                     if (!found_ff && rd_step == target_ff) begin
                        busy_ff[proc_idx_ff] <= 1'b0;
                        found_ff <= 1'b1;
                     end
                  end else begin
                     phase_ok_ff[proc_idx_ff] <= 1'b1;
                     sum_ff <= sum_ff + SUM_W'(wave_value(new_phase[31:24], wave_ff));
                     count_ff <= count_ff + 1'b1;
                  end
               end
               if (rd_idx_ff == CNT_W'(VOICES) && !proc_vld_ff)
                  state_ff <= is_release_ff ? ST_IDLE : ST_ENV;
            end
            ST_ENV: begin
               decay_sel_ff <= in_decay;
               state_ff <= ST_ENV_WAIT;
            end
            ST_ENV_WAIT: begin
               if (div_done) begin
                  level_ff <= decay_sel_ff ? 16'(17'd32768 - {1'b0, div_quo[15:0]})
                                           : div_quo[15:0];
                  state_ff <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               mean_ff <= '0;
               state_ff <= (count_ff != '0) ? ST_MEAN_WAIT : ST_SCALE;
            end
            ST_MEAN_WAIT: begin
               if (div_done) begin
                  mean_ff <= sum_neg ? -$signed(div_quo[8:0]) : $signed(div_quo[8:0]);
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               prod_ff <= 26'(mean_ff) * 26'($signed({1'b0, level_ff}));
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.audio_sample <= sample;
                  rsp_data_ff.voice_count <= 4'(count_ff);
                  if (tick_next >= {1'b0, tpm_ff}) begin
                     tick_ff <= '0;
                     if (elapsed_ff != 16'hFFFF) elapsed_ff <= elapsed_ff + 1'b1;
                  end else begin
                     tick_ff <= tick_next[7:0];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // a clear frees every slot
   `PDDS_ASSERT(a_clear_frees, clock, reset, (accept && req_data.func == FUNC_CLEAR) |=> (busy_ff == '0))
   // the shared divider is never restarted mid-divide
   `PDDS_ASSERT_NEVER(a_div_overlap, clock, reset, div_start && div_busy)
   // the mixed voice count never exceeds the slot count
   `PDDS_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(VOICES))
endmodule

// ===== sv/pdds_voice_mem.sv =====
// Voice step and phase memories, one read port and one write port each.
`timescale 1ns / 1ps
module pdds_voice_mem #(
   parameter int VOICES = 10,
   parameter int SLOT_W = 4
) (
   input  logic              clock,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [31:0]       rd_step,
   output logic [31:0]       rd_phase,
   input  logic              step_we,
   input  logic [SLOT_W-1:0] step_waddr,
   input  logic [31:0]       step_wdata,
   input  logic              phase_we,
   input  logic [SLOT_W-1:0] phase_waddr,
   input  logic [31:0]       phase_wdata
);
   logic [31:0] step_mem [VOICES];
   logic [31:0] phase_mem [VOICES];

   always_ff @(posedge clock) begin
      if (step_we) step_mem[step_waddr] <= step_wdata;
      if (phase_we) phase_mem[phase_waddr] <= phase_wdata;
      rd_step <= step_mem[rd_addr];
      rd_phase <= phase_mem[rd_addr];
   end
endmodule

// ===== sv/pdds_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pdds_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pdds_pkg::DIV_NUM_W-1:0]  num,
   input  logic [pdds_pkg::DIV_DEN_W-1:0]  den,
   output logic                            busy,
   output logic                            done,
   output logic [pdds_pkg::DIV_NUM_W-1:0]  quo
);
   import pdds_pkg::*;
   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W:0]   rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W+1:0] trial;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIV_NUM_W);
            quo_ff <= num;
            rem_ff <= '0;
            den_ff <= den;
         end else if (busy_ff) begin
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= (DIV_DEN_W+1)'(trial - {1'b0, den_ff});
               quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[DIV_DEN_W:0];
               quo_ff <= {quo_ff[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo = quo_ff;
endmodule
